// ----- rtl/core/nns_pkg.sv -----
// ---------------------------------------------------------------------------
// nns_pkg
// Types and constants shared by the nearest neighbour scaler and its channels.
// ---------------------------------------------------------------------------
package nns_pkg;

	localparam int COMP_W    = 8;   // one color component
	localparam int DIM_W     = 9;   // dimension registers and position counters
	localparam int POS_W     = 17;  // source load position
	localparam int PROD_W    = 18;  // products of two dimension-wide values
	localparam int DIV_STEPS = 9;   // quotient bits per position division
	localparam int CNT_W     = 4;   // division step counter
	localparam int WORD_W    = 32;  // stored pixel word
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FOUR_COMP  = 3'd4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_ADDR = 6'b001000,
		ST_READ = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

endpackage

// ----- rtl/core/nns_cmd_if.sv -----
// ---------------------------------------------------------------------------
// nns_cmd_if
// Command channel: pixel loads and output pixel requests.
// ---------------------------------------------------------------------------
interface nns_cmd_if;
	import nns_pkg::*;

	logic              valid;
	logic              ready;
	logic              cmd;
	logic [COMP_W-1:0] comp0;
	logic [COMP_W-1:0] comp1;
	logic [COMP_W-1:0] comp2;
	logic [COMP_W-1:0] comp3;

	modport source (output valid, cmd, comp0, comp1, comp2, comp3, input ready);
	modport sink   (input valid, cmd, comp0, comp1, comp2, comp3, output ready);

endinterface

// ----- rtl/core/nns_pix_if.sv -----
// ---------------------------------------------------------------------------
// nns_pix_if
// Output pixel channel: scaled pixel with its position and end-of-image flag.
// ---------------------------------------------------------------------------
interface nns_pix_if;
	import nns_pkg::*;

	logic              valid;
	logic              ready;
	logic [COMP_W-1:0] pix0;
	logic [COMP_W-1:0] pix1;
	logic [COMP_W-1:0] pix2;
	logic [COMP_W-1:0] pix3;
	logic [COMP_W-1:0] out_col;
	logic [COMP_W-1:0] out_row;
	logic              last_pixel;

	modport source (output valid, pix0, pix1, pix2, pix3, out_col, out_row, last_pixel,
		input ready);
	modport sink   (input valid, pix0, pix1, pix2, pix3, out_col, out_row, last_pixel,
		output ready);

endinterface

// ----- rtl/core/nearest_neighbour_image_scaler_top.sv -----
// ---------------------------------------------------------------------------
// nearest_neighbour_image_scaler_top
// Nearest neighbour rescaler for RGB/RGBA 8-bit images held in a pixel memory.
// ---------------------------------------------------------------------------
//  channel  direction  protocol      payload
//  cmd_ch   sink       valid/ready   cmd, comp0..comp3
//  pix_ch   source     valid/ready   pix0..pix3, out_col, out_row, last_pixel
//  apb      slave      psel/penable  5 registers at byte address 4*i
//
//  A load writes the pixel to memory at the transfer.
//  An emit runs through two products, a 9-step restoring division per
//  axis (one quotient bit a cycle), the address multiply, one memory read,
//  then the output register. One item is in work at a time.
//  The output register holds a finished pixel while pix_ch stalls; loads are
//  still taken meanwhile. Reset clears counters, sets sizes to one; memory stays.
// ---------------------------------------------------------------------------
module nearest_neighbour_image_scaler_top #(
	parameter int MAX_DIM      = 256,
	parameter int STORE_PIXELS = 65536
) (
	input  logic                         clk,
	input  logic                         arst_n,
	nns_cmd_if.sink                      cmd_ch,
	nns_pix_if.source                    pix_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [nns_pkg::PADDR_W-1:0]  paddr,
	input  logic [nns_pkg::PDATA_W-1:0]  pwdata,
	output logic [nns_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import nns_pkg::*;

	localparam int AW = $clog2(STORE_PIXELS);

	function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end
		return r;
	endfunction

	// configuration
	logic [DIM_W-1:0] in_width_q, in_height_q, out_width_q, out_height_q;
	logic             four_comp_q;
	logic             cfg_we;
	logic [REG_IDX_W-1:0] cfg_idx;

	// control
	state_t           state_q, state_d;
	logic [POS_W-1:0] load_pos_q;
	logic [DIM_W-1:0] emit_col_q, emit_row_q;
	logic [CNT_W-1:0] div_cnt_q;

	// per-item work registers
	logic [DIM_W-1:0]  iw_q, ih_q, ow_q, oh_q;
	logic [DIM_W-1:0]  col_q, row_q;
	logic              last_q;
	logic [PROD_W-1:0] remx_q, remy_q;
	logic [DIM_W-1:0]  sx_q, sy_q;
	logic [PROD_W-1:0] addr_q;
	logic              in_range_q;
	logic [WORD_W-1:0] rdata_q;
	logic              out_valid_q;

	logic [WORD_W-1:0] mem [STORE_PIXELS];

	logic [DIM_W-1:0]  iw, ih, ow, oh;
	logic [DIM_W-1:0]  col_cur, row_cur;
	logic [PROD_W-1:0] load_limit;
	logic              cmd_xfer, load_xfer, emit_xfer, load_we;
	logic              out_free;
	logic [PROD_W-1:0] divx, divy;
	logic              gex, gey;
	logic [WORD_W-1:0] word;

	assign iw = dim_eff(in_width_q);
	assign ih = dim_eff(in_height_q);
	assign ow = dim_eff(out_width_q);
	assign oh = dim_eff(out_height_q);

	// ---------------- APB ----------------
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= DIM_W'(1);
			in_height_q  <= DIM_W'(1);
			out_width_q  <= DIM_W'(1);
			out_height_q <= DIM_W'(1);
			four_comp_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_IN_WIDTH:   in_width_q   <= pwdata[DIM_W-1:0];
				REG_IN_HEIGHT:  in_height_q  <= pwdata[DIM_W-1:0];
				REG_OUT_WIDTH:  out_width_q  <= pwdata[DIM_W-1:0];
				REG_OUT_HEIGHT: out_height_q <= pwdata[DIM_W-1:0];
				REG_FOUR_COMP:  four_comp_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_IN_WIDTH:   prdata = PDATA_W'(in_width_q);
			REG_IN_HEIGHT:  prdata = PDATA_W'(in_height_q);
			REG_OUT_WIDTH:  prdata = PDATA_W'(out_width_q);
			REG_OUT_HEIGHT: prdata = PDATA_W'(out_height_q);
			REG_FOUR_COMP:  prdata = PDATA_W'(four_comp_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- command side ----------------
	assign cmd_ch.ready = (state_q == ST_IDLE);
	assign cmd_xfer     = cmd_ch.valid && cmd_ch.ready;
	assign load_xfer    = cmd_xfer && (cmd_ch.cmd == CMD_LOAD);
	assign emit_xfer    = cmd_xfer && (cmd_ch.cmd == CMD_EMIT);

	assign load_limit = PROD_W'(iw) * PROD_W'(ih);
	// drop loads past the image or past the memory
	assign load_we = load_xfer && (PROD_W'(load_pos_q) < load_limit)
		&& (32'(load_pos_q) < STORE_PIXELS);

	// restart counters left out of range by a register write
	assign col_cur = (emit_col_q >= ow) ? '0 : emit_col_q;
	assign row_cur = (emit_row_q >= oh) ? '0 : emit_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			emit_col_q <= '0;
			emit_row_q <= '0;
		end else begin
			if (load_we) begin
				load_pos_q <= load_pos_q + POS_W'(1);
			end
			if (emit_xfer) begin
				if (col_cur + DIM_W'(1) < ow) begin
					emit_col_q <= col_cur + DIM_W'(1);
					emit_row_q <= row_cur;
				end else begin
					emit_col_q <= '0;
					emit_row_q <= (row_cur + DIM_W'(1) < oh) ? row_cur + DIM_W'(1) : '0;
				end
			end
		end
	end

	// ---------------- sequencer ----------------
	assign out_free = !out_valid_q || pix_ch.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (emit_xfer) state_d = ST_MUL;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  if (div_cnt_q == '0) state_d = ST_ADDR;
			ST_ADDR: state_d = ST_READ;
			ST_READ: state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) begin
				div_cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q - CNT_W'(1);
			end
		end
	end

	// one quotient bit per cycle and axis, largest first
	assign divx = PROD_W'(ow_q) << div_cnt_q;
	assign divy = PROD_W'(oh_q) << div_cnt_q;
	assign gex  = remx_q >= divx;
	assign gey  = remy_q >= divy;

	always_ff @(posedge clk) begin
		if (emit_xfer) begin
			iw_q   <= iw;
			ih_q   <= ih;
			ow_q   <= ow;
			oh_q   <= oh;
			col_q  <= col_cur;
			row_q  <= row_cur;
			last_q <= (col_cur == ow - DIM_W'(1)) && (row_cur == oh - DIM_W'(1));
		end
		case (state_q)
			ST_MUL: begin
				remx_q <= PROD_W'(col_q) * PROD_W'(iw_q);
				remy_q <= PROD_W'(row_q) * PROD_W'(ih_q);
				sx_q   <= '0;
				sy_q   <= '0;
			end
			ST_DIV: begin
				remx_q <= gex ? remx_q - divx : remx_q;
				remy_q <= gey ? remy_q - divy : remy_q;
				sx_q   <= {sx_q[DIM_W-2:0], gex};
				sy_q   <= {sy_q[DIM_W-2:0], gey};
			end
			ST_ADDR: begin
				addr_q <= PROD_W'(sy_q) * PROD_W'(iw_q) + PROD_W'(sx_q);
			end
			ST_READ: begin
				in_range_q <= 32'(addr_q) < STORE_PIXELS;
			end
			default: ;
		endcase
	end

	// ---------------- pixel memory ----------------
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[AW'(load_pos_q)] <= {cmd_ch.comp3, cmd_ch.comp2, cmd_ch.comp1, cmd_ch.comp0};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rdata_q <= mem[AW'(addr_q)];
		end
	end

	// ---------------- output register ----------------
	assign word = in_range_q ? rdata_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pix_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			pix_ch.pix0       <= word[7:0];
			pix_ch.pix1       <= word[15:8];
			pix_ch.pix2       <= word[23:16];
			pix_ch.pix3       <= four_comp_q ? word[31:24] : '0;
			pix_ch.out_col    <= col_q[COMP_W-1:0];
			pix_ch.out_row    <= row_q[COMP_W-1:0];
			pix_ch.last_pixel <= last_q;
		end
	end

	assign pix_ch.valid = out_valid_q;

`ifndef SYNTHESIS
	a_emit_starts: assert property (@(posedge clk) disable iff (!arst_n)
		emit_xfer |=> state_q == ST_MUL)
		else $error("emit transfer did not start the sequencer");

	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADDR |-> (sx_q < iw_q) && (sy_q < ih_q)
			&& (remx_q < PROD_W'(ow_q)) && (remy_q < PROD_W'(oh_q)))
		else $error("source position division out of range");

	a_load_hold: assert property (@(posedge clk) disable iff (!arst_n)
		load_xfer && !load_we |=> $stable(load_pos_q))
		else $error("dropped load moved the load position");
`endif

endmodule

// ----- tb/nns_scaler_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// nns_scaler_checker
// Passive checker for the nearest neighbour scaler. Tracks register writes,
// source pixel loads and output pixel requests, computes every scaled pixel
// from its own copy of the pixel memory, and compares each pixel transfer
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module nns_scaler_checker
	import nns_pkg::*;
#(
	parameter int MAX_DIM      = 256,
	parameter int STORE_PIXELS = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	nns_cmd_if                 cmd_mon,
	nns_pix_if                 pix_mon,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 outstanding,
	output int                 fail_count
);

	typedef struct packed {
		logic [COMP_W-1:0] pix0;
		logic [COMP_W-1:0] pix1;
		logic [COMP_W-1:0] pix2;
		logic [COMP_W-1:0] pix3;
		logic [COMP_W-1:0] out_col;
		logic [COMP_W-1:0] out_row;
		logic              last_pixel;
	} scaled_pixel_t;

	logic [WORD_W-1:0] source_mem [STORE_PIXELS];
	logic [POS_W-1:0]  load_pos;
	logic [DIM_W-1:0]  next_col;
	logic [DIM_W-1:0]  next_row;
	logic [DIM_W-1:0]  cfg_in_w;
	logic [DIM_W-1:0]  cfg_in_h;
	logic [DIM_W-1:0]  cfg_out_w;
	logic [DIM_W-1:0]  cfg_out_h;
	logic              cfg_rgba;
	scaled_pixel_t     predicted_pixels [$];
	int                mismatches;

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return 32'(v);
	endfunction

	// Advances the output raster position as a side effect.
	function automatic scaled_pixel_t scale_next_pixel();
		int unsigned       iw, ih, ow, oh, src_x, src_y, src_idx;
		logic [WORD_W-1:0] word;
		scaled_pixel_t     px;
		iw = clamp_dim(cfg_in_w);
		ih = clamp_dim(cfg_in_h);
		ow = clamp_dim(cfg_out_w);
		oh = clamp_dim(cfg_out_h);
		// a register write may have left the position outside the output image
		if (next_col >= ow)
			next_col = '0;
		if (next_row >= oh)
			next_row = '0;
		src_y   = (next_row * ih) / oh;
		src_x   = (next_col * iw) / ow;
		src_idx = src_y * iw + src_x;
		word    = (src_idx < STORE_PIXELS) ? source_mem[src_idx] : '0;
		px.pix0       = word[7:0];
		px.pix1       = word[15:8];
		px.pix2       = word[23:16];
		px.pix3       = cfg_rgba ? word[31:24] : '0;
		px.out_col    = next_col[COMP_W-1:0];
		px.out_row    = next_row[COMP_W-1:0];
		px.last_pixel = (next_col == ow - 1) && (next_row == oh - 1);
		if (next_col + 1 < ow) begin
			next_col = next_col + 1'b1;
		end else begin
			next_col = '0;
			if (next_row + 1 < oh)
				next_row = next_row + 1'b1;
			else
				next_row = '0;
		end
		return px;
	endfunction

	function automatic void compare_field(input string name, input logic [COMP_W-1:0] want,
		input logic [COMP_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		scaled_pixel_t want;
		int unsigned   load_limit;
		if (!arst_n) begin
			load_pos   = '0;
			next_col   = '0;
			next_row   = '0;
			cfg_in_w   = 9'd1;
			cfg_in_h   = 9'd1;
			cfg_out_w  = 9'd1;
			cfg_out_h  = 9'd1;
			cfg_rgba   = 1'b0;
			mismatches = 0;
			predicted_pixels.delete();
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			// compare before pushing: a pixel leaving now belongs to an older request
			if (pix_mon.valid && pix_mon.ready) begin
				if (predicted_pixels.size() == 0) begin
					$error("pixel transfer with no pixel expected: col %0d row %0d",
						pix_mon.out_col, pix_mon.out_row);
					mismatches++;
				end else begin
					want = predicted_pixels.pop_front();
					compare_field("pix0", want.pix0, pix_mon.pix0);
					compare_field("pix1", want.pix1, pix_mon.pix1);
					compare_field("pix2", want.pix2, pix_mon.pix2);
					compare_field("pix3", want.pix3, pix_mon.pix3);
					compare_field("out_col", want.out_col, pix_mon.out_col);
					compare_field("out_row", want.out_row, pix_mon.out_row);
					compare_field("last_pixel", COMP_W'(want.last_pixel),
						COMP_W'(pix_mon.last_pixel));
				end
			end
			if (cmd_mon.valid && cmd_mon.ready) begin
				if (cmd_mon.cmd == CMD_EMIT) begin
					predicted_pixels.push_back(scale_next_pixel());
				end else begin
					load_limit = clamp_dim(cfg_in_w) * clamp_dim(cfg_in_h);
					// drop loads past the source image
					if (load_pos < load_limit && load_pos < STORE_PIXELS) begin
						source_mem[load_pos] = {cmd_mon.comp3, cmd_mon.comp2,
							cmd_mon.comp1, cmd_mon.comp0};
						load_pos = load_pos + 1'b1;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_IN_WIDTH:   cfg_in_w  = pwdata[DIM_W-1:0];
					REG_IN_HEIGHT:  cfg_in_h  = pwdata[DIM_W-1:0];
					REG_OUT_WIDTH:  cfg_out_w = pwdata[DIM_W-1:0];
					REG_OUT_HEIGHT: cfg_out_h = pwdata[DIM_W-1:0];
					REG_FOUR_COMP:  cfg_rgba  = pwdata[0];
					default: ;
				endcase
			end
			outstanding <= predicted_pixels.size();
			fail_count  <= mismatches;
		end
	end

endmodule

// ----- tb/tb_nearest_neighbour_image_scaler_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_nearest_neighbour_image_scaler_top
// Drives the scaler through a sequence of register settings: each phase loads
// the source image, then requests output pixels, mixed in random phases with
// loads past the image. A separate checker predicts and compares every pixel.
// ---------------------------------------------------------------------------
module tb_nearest_neighbour_image_scaler_top;
	import nns_pkg::*;

	localparam int MAX_DIM        = 256;
	localparam int STORE_PIXELS   = 65536;
	localparam int RESET_CYCLES   = 11;
	localparam int DRAIN_CYCLES   = 20;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int STALL_LIMIT    = 2000;
	localparam int ITEM_TARGET    = 1000;
	localparam int AREA_CAP       = 512;
	localparam int IDLE_PERCENT   = 25;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	nns_cmd_if cmd_ch ();
	nns_pix_if pix_ch ();

	int   outstanding;
	int   fail_count;
	logic no_idle;
	int   holds_asked;
	int   load_area;
	int   loaded;
	int   loads_ignored;
	int   emits_sent;
	int   settings_used;
	int   idle_count = 0;

	nearest_neighbour_image_scaler_top #(
		.MAX_DIM      (MAX_DIM),
		.STORE_PIXELS (STORE_PIXELS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_ch  (cmd_ch),
		.pix_ch  (pix_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	nns_scaler_checker #(
		.MAX_DIM      (MAX_DIM),
		.STORE_PIXELS (STORE_PIXELS)
	) pixel_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_mon     (cmd_ch),
		.pix_mon     (pix_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int effective_dim(input logic [DIM_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return 32'(v);
	endfunction

	// mostly small sizes, sometimes zero, the maximum or oversize values
	function automatic logic [DIM_W-1:0] pick_dim(input int common_max);
		case ($urandom_range(9))
			0:       return '0;
			1:       return DIM_W'(MAX_DIM);
			2:       return DIM_W'($urandom_range(MAX_DIM + 1, 511));
			3:       return DIM_W'($urandom_range(common_max + 1, MAX_DIM));
			default: return DIM_W'($urandom_range(1, common_max));
		endcase
	endfunction

	task automatic send_item(input logic op, input logic [WORD_W-1:0] pixel);
		while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.cmd   <= op;
		cmd_ch.comp0 <= pixel[7:0];
		cmd_ch.comp1 <= pixel[15:8];
		cmd_ch.comp2 <= pixel[23:16];
		cmd_ch.comp3 <= pixel[31:24];
		do @(posedge clk); while (!cmd_ch.ready);
		if (op == CMD_EMIT)
			emits_sent++;
		else if (loaded < load_area)
			loaded++;
		else
			loads_ignored++;
	endtask

	// leaves psel high so back-to-back writes need one assignment per edge
	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// stop offering items, then wait until every requested pixel has left
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [DIM_W-1:0] iw, ih, ow, oh, input logic rgba);
		logic [PDATA_W-1:0] junk;
		wait_drained();
		// unused upper bits carry noise
		junk = $urandom;
		apb_write(REG_IN_WIDTH, {junk[PDATA_W-1:DIM_W], iw});
		junk = $urandom;
		apb_write(REG_IN_HEIGHT, {junk[PDATA_W-1:DIM_W], ih});
		junk = $urandom;
		apb_write(REG_OUT_WIDTH, {junk[PDATA_W-1:DIM_W], ow});
		junk = $urandom;
		apb_write(REG_OUT_HEIGHT, {junk[PDATA_W-1:DIM_W], oh});
		junk = $urandom;
		apb_write(REG_FOUR_COMP, {junk[PDATA_W-1:1], rgba});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		load_area = effective_dim(iw) * effective_dim(ih);
		settings_used++;
	endtask

	task automatic run_phase(input logic [DIM_W-1:0] iw, ih, ow, oh, input logic rgba,
		input int n_emits, input bit directed, input bit hold_output);
		int sent;
		configure(iw, ih, ow, oh, rgba);
		// fill every source entry the output pass can read
		while (loaded < load_area)
			send_item(CMD_LOAD, directed ? ((loaded % 2) ? 32'h0 : 32'hFFFF_FFFF) : $urandom);
		if (hold_output)
			holds_asked <= holds_asked + 1;
		sent = 0;
		while (sent < n_emits) begin
			if (!directed && $urandom_range(9) == 0) begin
				send_item(CMD_LOAD, $urandom);
			end else begin
				send_item(CMD_EMIT, $urandom);
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		logic [DIM_W-1:0] iw, ih, ow, oh;
		int               phase_no;
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.cmd   <= CMD_LOAD;
		cmd_ch.comp0 <= '0;
		cmd_ch.comp1 <= '0;
		cmd_ch.comp2 <= '0;
		cmd_ch.comp3 <= '0;
		no_idle      <= 1'b0;
		holds_asked  <= 0;
		load_area     = 1;
		loaded        = 0;
		loads_ignored = 0;
		emits_sent    = 0;
		settings_used = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: 1x1 in RGB, so the stored fourth byte must read as zero
		send_item(CMD_LOAD, 32'hFFFF_FFFF);
		send_item(CMD_EMIT, $urandom);
		send_item(CMD_LOAD, 32'h0);
		send_item(CMD_EMIT, $urandom);
		// zero width acts as one, oversize height as the maximum
		run_phase(9'd0, 9'd2, 9'd3, 9'd511, 1'b1, 4, 1'b1, 1'b0);
		run_phase(9'd2, 9'd3, 9'd5, 9'd4, 1'b0, 8, 1'b1, 1'b0);

		phase_no = 0;
		while (loaded + emits_sent < ITEM_TARGET || phase_no < 4) begin
			case (phase_no)
				0: begin
					iw = 9'd511; ih = 9'd2; ow = DIM_W'(MAX_DIM); oh = DIM_W'(MAX_DIM);
				end
				1: begin
					iw = 9'd1; ih = DIM_W'(MAX_DIM); ow = 9'd1; oh = 9'd3;
				end
				default: begin
					iw = pick_dim(16);
					ih = pick_dim(16);
					ow = pick_dim(12);
					oh = pick_dim(12);
					if (effective_dim(iw) * effective_dim(ih) > AREA_CAP) begin
						if ($urandom_range(1))
							iw = DIM_W'($urandom_range(1, 2));
						else
							ih = DIM_W'($urandom_range(1, 2));
					end
				end
			endcase
			no_idle <= (phase_no == 3);
			if (phase_no == 1)
				run_phase(iw, ih, ow, oh, 1'b1, 40, 1'b0, 1'b1);
			else
				run_phase(iw, ih, ow, oh, 1'($urandom_range(1)), $urandom_range(10, 60),
					1'b0, 1'b0);
			phase_no++;
		end
		wait_drained();

		$display("Covered %0d source loads (%0d past the image) and %0d output pixels",
			loaded, loads_ignored, emits_sent);
		$display("over %0d scaler settings, with a long output hold-off and a gap-free phase",
			settings_used);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : pixel_sink
		int holds_done;
		holds_done = 0;
		pix_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_asked != holds_done) begin
				// hold off so the output register fills and the input stalls
				holds_done++;
				pix_ch.ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end else begin
				pix_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready)
			|| (psel && penable)) begin
			idle_count <= 0;
		end else if (idle_count >= STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

endmodule

// ----- nearest_neighbour_image_scaler_top.f -----
rtl/core/nns_pkg.sv
rtl/core/nns_cmd_if.sv
rtl/core/nns_pix_if.sv
rtl/core/nearest_neighbour_image_scaler_top.sv
tb/nns_scaler_checker.sv
tb/tb_nearest_neighbour_image_scaler_top.sv
